// File: rtl/esc_pkg.sv
`timescale 1ns / 1ps

package esc_pkg;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_Y     = 8'h79;
    localparam logic [7:0] CASE_BIT = 8'h20;

    localparam logic [2:0] ERR_OK           = 3'd0;
    localparam logic [2:0] ERR_EMPTY        = 3'd1;
    localparam logic [2:0] ERR_EMPTY_PARENS = 3'd2;
    localparam logic [2:0] ERR_EARLY_CLOSE  = 3'd3;
    localparam logic [2:0] ERR_UNCLOSED     = 3'd4;
    localparam logic [2:0] ERR_UNDEF_VAR    = 3'd5;
    localparam logic [2:0] ERR_TWO_OPS      = 3'd6;
    localparam logic [2:0] ERR_TWO_LETTERS  = 3'd7;

    localparam int VAR_COUNT_W = 5;

    typedef struct packed {
        logic [7:0] character;
        logic       is_last;
        logic       no_character;
    } t_in_item;

    typedef struct packed {
        logic       malformed;
        logic [2:0] error_code;
    } t_out_item;

    typedef struct packed {
        logic is_letter;
        logic is_operator;
        logic is_open;
        logic is_close;
        logic is_newline;
        logic is_undef;
    } t_char_class;

endpackage

// File: rtl/expression_syntax_checker.sv
`timescale 1ns / 1ps

// Expression syntax checker: takes one byte of an expression per item and, on
// the item flagged last, delivers one verdict (malformed plus a 3-bit code).
// Items are taken one per cycle, except while a last item in the input register
// waits behind an earlier verdict still held under output stall; the running
// scan state (depth, length, sticky flags) is updated as each item leaves the
// input register. The verdict for the last item is then registered at the output,
// unless an earlier verdict still waits there under stall. Items
// that carry no byte and are not last only pass through. variable_count sits
// at APB byte address 0 and must be written only while the block is idle.
module expression_syntax_checker
    import esc_pkg::*;
#(
    parameter int MAX_DEPTH = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic REG_VAR_COUNT = 1'b0;

    logic                   r_in_valid;
    t_in_item               r_in;
    logic                   r_out_valid;
    t_out_item              r_out;
    logic [VAR_COUNT_W-1:0] r_var_count;
    logic                   w_accept;
    logic                   w_adv;
    t_out_item              w_result;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_VAR_COUNT)
                  ? {{(32 - VAR_COUNT_W){1'b0}}, r_var_count} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_var_count <= '0;
        end else if (psel && penable && pwrite && (paddr[2] == REG_VAR_COUNT)) begin
            r_var_count <= pwdata[VAR_COUNT_W-1:0];
        end
    end

    assign w_adv      = r_in_valid && (!r_in.is_last || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_adv;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_item;
        end
    end

    esc_scan #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_adv),
        .i_item      (r_in),
        .i_var_count (r_var_count),
        .o_result    (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && r_in.is_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in.is_last) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_verdict_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.malformed == (o_out_item.error_code != ERR_OK)))
        else $error("malformed flag disagrees with code");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_in.is_last && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked verdict");

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(w_adv && r_in.is_last) && $past(i_rst_n) && !$past(r_out_valid))
        |-> !o_out_valid)
        else $error("result without a last item");

endmodule

// File: rtl/esc_char_class.sv
`timescale 1ns / 1ps

module esc_char_class
    import esc_pkg::*;
(
    input  logic [7:0]             i_char,
    input  logic [VAR_COUNT_W-1:0] i_var_count,
    output t_char_class            o_class
);

    logic       w_letter;
    logic       w_punct;
    logic [7:0] w_low;
    logic [7:0] w_offset;

    assign w_letter = ((i_char >= 8'h41) && (i_char <= 8'h5A)) ||
                      ((i_char >= 8'h61) && (i_char <= 8'h7A));
    assign w_punct  = ((i_char >= 8'd33)  && (i_char <= 8'd47))  ||
                      ((i_char >= 8'd58)  && (i_char <= 8'd64))  ||
                      ((i_char >= 8'd91)  && (i_char <= 8'd96))  ||
                      ((i_char >= 8'd123) && (i_char <= 8'd126));
    assign w_low    = i_char | CASE_BIT;
    assign w_offset = w_low - CH_A;

    always_comb begin
        o_class.is_letter   = w_letter;
        o_class.is_open     = (i_char == CH_OPEN);
        o_class.is_close    = (i_char == CH_CLOSE);
        o_class.is_operator = w_punct && (i_char != CH_OPEN) && (i_char != CH_CLOSE);
        o_class.is_newline  = (i_char == CH_LF);
        o_class.is_undef    = w_letter && (w_low != CH_X) && (w_low != CH_Y) &&
                              (w_offset >= {{(8 - VAR_COUNT_W){1'b0}}, i_var_count});
    end

endmodule

// File: rtl/esc_scan.sv
`timescale 1ns / 1ps

module esc_scan
    import esc_pkg::*;
#(
    parameter int MAX_DEPTH = 255
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  t_in_item               i_item,
    input  logic [VAR_COUNT_W-1:0] i_var_count,
    output t_out_item              o_result
);

    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_DEPTH);

    t_char_class w_cls;

    logic               r_prev_open,     n_prev_open;
    logic               r_prev_op,       n_prev_op;
    logic               r_prev_letter,   n_prev_letter;
    logic               r_first_newline, n_first_newline;
    logic [1:0]         r_length,        n_length;
    logic [DEPTH_W-1:0] r_depth,         n_depth;
    logic               r_overflow,      n_overflow;
    logic               r_f_empty_par,   n_f_empty_par;
    logic               r_f_early,       n_f_early;
    logic               r_f_undef,       n_f_undef;
    logic               r_f_two_ops,     n_f_two_ops;
    logic               r_f_two_let,     n_f_two_let;
    logic               w_take;

    esc_char_class u_class (
        .i_char      (i_item.character),
        .i_var_count (i_var_count),
        .o_class     (w_cls)
    );

    assign w_take = i_step && !i_item.no_character;

    always_comb begin
        n_prev_open     = r_prev_open;
        n_prev_op       = r_prev_op;
        n_prev_letter   = r_prev_letter;
        n_first_newline = r_first_newline;
        n_length        = r_length;
        n_depth         = r_depth;
        n_overflow      = r_overflow;
        n_f_empty_par   = r_f_empty_par;
        n_f_early       = r_f_early;
        n_f_undef       = r_f_undef;
        n_f_two_ops     = r_f_two_ops;
        n_f_two_let     = r_f_two_let;
        if (w_take) begin
            if (r_length == 2'd0) begin
                n_first_newline = w_cls.is_newline;
            end
            if (r_length != 2'd2) begin
                n_length = r_length + 2'd1;
            end
            n_f_empty_par = r_f_empty_par | (r_prev_open && w_cls.is_close);
            n_f_two_ops   = r_f_two_ops | (r_prev_op && w_cls.is_operator);
            n_f_two_let   = r_f_two_let | (r_prev_letter && w_cls.is_letter);
            n_f_undef     = r_f_undef | w_cls.is_undef;
            if (w_cls.is_open) begin
                if (r_depth >= DEPTH_MAX) begin
                    n_overflow = 1'b1;
                end else begin
                    n_depth = r_depth + DEPTH_W'(1);
                end
            end else if (w_cls.is_close) begin
                if (r_depth == '0) begin
                    n_f_early = r_f_early | !r_overflow;
                end else begin
                    n_depth = r_depth - DEPTH_W'(1);
                end
            end
            n_prev_open   = w_cls.is_open;
            n_prev_op     = w_cls.is_operator;
            n_prev_letter = w_cls.is_letter;
        end
    end

    always_comb begin
        priority if ((n_length == 2'd0) || ((n_length == 2'd1) && n_first_newline)) begin
            o_result.error_code = ERR_EMPTY;
        end else if (n_f_empty_par) begin
            o_result.error_code = ERR_EMPTY_PARENS;
        end else if (n_f_early) begin
            o_result.error_code = ERR_EARLY_CLOSE;
        end else if (n_overflow || (n_depth != '0)) begin
            o_result.error_code = ERR_UNCLOSED;
        end else if (n_f_undef) begin
            o_result.error_code = ERR_UNDEF_VAR;
        end else if (n_f_two_ops) begin
            o_result.error_code = ERR_TWO_OPS;
        end else if (n_f_two_let) begin
            o_result.error_code = ERR_TWO_LETTERS;
        end else begin
            o_result.error_code = ERR_OK;
        end
        o_result.malformed = (o_result.error_code != ERR_OK);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_item.is_last)) begin
            r_prev_open     <= 1'b0;
            r_prev_op       <= 1'b0;
            r_prev_letter   <= 1'b0;
            r_first_newline <= 1'b0;
            r_length        <= 2'd0;
            r_depth         <= '0;
            r_overflow      <= 1'b0;
            r_f_empty_par   <= 1'b0;
            r_f_early       <= 1'b0;
            r_f_undef       <= 1'b0;
            r_f_two_ops     <= 1'b0;
            r_f_two_let     <= 1'b0;
        end else begin
            r_prev_open     <= n_prev_open;
            r_prev_op       <= n_prev_op;
            r_prev_letter   <= n_prev_letter;
            r_first_newline <= n_first_newline;
            r_length        <= n_length;
            r_depth         <= n_depth;
            r_overflow      <= n_overflow;
            r_f_empty_par   <= n_f_empty_par;
            r_f_early       <= n_f_early;
            r_f_undef       <= n_f_undef;
            r_f_two_ops     <= n_f_two_ops;
            r_f_two_let     <= n_f_two_let;
        end
    end

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_MAX)
        else $error("paren depth above bound");

    a_overflow_needs_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overflow |-> (r_length == 2'd2))
        else $error("overflow flag set on a short expression");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.is_last) |=> ((r_depth == '0) && (r_length == 2'd0) && !r_overflow))
        else $error("state not cleared after verdict");

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
    import esc_pkg::*;

    localparam int DEPTH_LIMIT = 255;
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS = 100;
    localparam logic [2:0] ADDR_VAR_COUNT = 3'd0;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    t_in_item in_item = '0;
    logic out_stall = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    wire in_stall;
    wire out_valid;
    t_out_item out_item;
    wire [31:0] prdata;
    wire pready;

    expression_syntax_checker #(
        .MAX_DEPTH(DEPTH_LIMIT)
    ) dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_stall(in_stall),
        .i_in_item(in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item(out_item),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #10 clk = ~clk;

    t_in_item item_q[$];
    t_out_item verdict_q[$];
    logic [7:0] text[$];
    int fed_items = 0;
    int mismatches = 0;
    int quiet_cycles = 0;
    int in_gap = 0;
    int stall_left = 0;
    bit calm = 1'b0;

    // scan state of the checker as seen from outside
    logic [4:0] var_limit = '0;
    logic [7:0] prev_ch = '0;
    logic [7:0] first_ch = '0;
    bit have_prev = 1'b0;
    logic [1:0] len_seen = '0;
    int depth = 0;
    bit overflowed = 1'b0;
    bit f_empty_parens = 1'b0;
    bit f_early_close = 1'b0;
    bit f_undef_var = 1'b0;
    bit f_two_ops = 1'b0;
    bit f_two_letters = 1'b0;

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit is_punct(logic [7:0] c);
        return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
               (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
    endfunction

    function automatic bit is_op(logic [7:0] c);
        return is_punct(c) && c != CH_OPEN && c != CH_CLOSE;
    endfunction

    task automatic scan_item(t_in_item it);
        logic [7:0] c;
        logic [7:0] low;
        logic [2:0] code;
        c = it.character;
        if (!it.no_character) begin
            if (len_seen == 0) first_ch = c;
            if (len_seen < 2) len_seen++;
            if (have_prev) begin
                if (prev_ch == CH_OPEN && c == CH_CLOSE) f_empty_parens = 1'b1;
                if (is_op(prev_ch) && is_op(c)) f_two_ops = 1'b1;
                if (is_alpha(prev_ch) && is_alpha(c)) f_two_letters = 1'b1;
            end
            if (c == CH_OPEN) begin
                if (depth >= DEPTH_LIMIT) overflowed = 1'b1;
                else depth++;
            end else if (c == CH_CLOSE) begin
                if (depth == 0) begin
                    if (!overflowed) f_early_close = 1'b1;
                end else begin
                    depth--;
                end
            end
            if (is_alpha(c)) begin
                low = c | CASE_BIT;
                if (low != CH_X && low != CH_Y && (low - CH_A) >= var_limit)
                    f_undef_var = 1'b1;
            end
            prev_ch = c;
            have_prev = 1'b1;
        end
        if (it.is_last) begin
            if (len_seen == 0 || (len_seen == 1 && first_ch == CH_LF)) code = ERR_EMPTY;
            else if (f_empty_parens) code = ERR_EMPTY_PARENS;
            else if (f_early_close) code = ERR_EARLY_CLOSE;
            else if (overflowed || depth != 0) code = ERR_UNCLOSED;
            else if (f_undef_var) code = ERR_UNDEF_VAR;
            else if (f_two_ops) code = ERR_TWO_OPS;
            else if (f_two_letters) code = ERR_TWO_LETTERS;
            else code = ERR_OK;
            verdict_q.push_back('{malformed: code != ERR_OK, error_code: code});
            prev_ch = '0;
            first_ch = '0;
            have_prev = 1'b0;
            len_seen = '0;
            depth = 0;
            overflowed = 1'b0;
            f_empty_parens = 1'b0;
            f_early_close = 1'b0;
            f_undef_var = 1'b0;
            f_two_ops = 1'b0;
            f_two_letters = 1'b0;
        end
    endtask

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [7:0] pick_op();
        case ($urandom_range(0, 7))
            0: return "+";
            1: return "-";
            2: return "*";
            3: return "/";
            4: return "^";
            5: return "%";
            6: return "=";
            default: return "!";
        endcase
    endfunction

    function automatic logic [7:0] pick_letter();
        logic [7:0] c;
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) c = r[0] ? CH_X : CH_Y;
        else if (r < 7 && var_limit != 0) c = 8'(CH_A + $urandom_range(0, var_limit - 1));
        else c = 8'(CH_A + $urandom_range(0, 25));
        if ($urandom_range(0, 3) == 0) c = c ^ CASE_BIT;
        return c;
    endfunction

    task automatic push_item(logic [7:0] c, bit last, bit none);
        item_q.push_back('{character: c, is_last: last, no_character: none});
        if (!none || last) fed_items++;
    endtask

    task automatic send_text(bit split_end, bit noisy);
        bit end_alone;
        end_alone = split_end || text.size() == 0;
        foreach (text[i]) begin
            if (noisy && $urandom_range(0, 3) == 0)
                push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            push_item(text[i], !end_alone && i == text.size() - 1, 1'b0);
        end
        if (end_alone) push_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    endtask

    task automatic gen_term(int budget);
        int r;
        r = $urandom_range(0, 9);
        if (budget > 0 && r < 3) begin
            text.push_back(CH_OPEN);
            gen_expr(budget - 1);
            text.push_back(CH_CLOSE);
        end else if (r < 7) begin
            text.push_back(pick_letter());
        end else begin
            text.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        end
    endtask

    task automatic gen_expr(int budget);
        int n;
        gen_term(budget);
        n = $urandom_range(0, 3);
        repeat (n) begin
            if ($urandom_range(0, 9) == 0) text.push_back(CH_SPACE);
            text.push_back(pick_op());
            gen_term(budget);
        end
    endtask

    task automatic mutate();
        int pos;
        logic [7:0] b;
        case ($urandom_range(0, 4))
            0: b = CH_OPEN;
            1: b = CH_CLOSE;
            2: b = pick_op();
            3: b = pick_letter();
            default: b = 8'($urandom_range(0, 255));
        endcase
        pos = $urandom_range(0, text.size());
        case ($urandom_range(0, 2))
            0: if (pos < text.size()) text[pos] = b;
            1: text.insert(pos, b);
            default: if (pos < text.size() && text.size() > 1) text.delete(pos);
        endcase
    endtask

    task automatic add_expression();
        int r;
        int n;
        text.delete();
        r = $urandom_range(0, 99);
        if (r < 4) begin
            if (r < 2) text.push_back(CH_LF);
        end else begin
            gen_expr($urandom_range(0, 3));
            if ($urandom_range(0, 99) < 40) begin
                n = $urandom_range(1, 3);
                repeat (n) mutate();
            end
        end
        send_text($urandom_range(0, 99) < 15, $urandom_range(0, 99) < 10);
    endtask

    task automatic add_deep(int opens, int closes);
        text.delete();
        repeat (opens) text.push_back(CH_OPEN);
        text.push_back(CH_X);
        repeat (closes) text.push_back(CH_CLOSE);
        send_text(1'b0, 1'b0);
    endtask

    task automatic write_var_count(logic [4:0] v);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_VAR_COUNT;
        pwdata <= 32'(v);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        var_limit = v;
    endtask

    task automatic settle();
        while (item_q.size() != 0 || in_valid || verdict_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !in_stall) begin
            if (in_gap > 0) begin
                in_gap--;
                in_valid <= 1'b0;
            end else if (item_q.size() > 0) begin
                in_item <= item_q.pop_front();
                in_valid <= 1'b1;
                in_gap = pick_gap();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else begin
            stall_left = pick_gap();
            out_stall <= stall_left > 0;
            if (stall_left > 0) stall_left--;
        end
    end

    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall) scan_item(in_item);
    end

    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (verdict_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected verdict: malformed=%0b code=%0d",
                             out_item.malformed, out_item.error_code);
            end else begin
                want = verdict_q.pop_front();
                if (out_item.malformed !== want.malformed ||
                    out_item.error_code !== want.error_code) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("verdict mismatch: expected malformed=%0b code=%0d, got malformed=%0b code=%0d",
                                 want.malformed, want.error_code,
                                 out_item.malformed, out_item.error_code);
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        string cases[$];
        logic [4:0] limit;
        int goal;
        cases = '{"\n", "()", ")(", "(x", "d", "x+*C", "ab", "(Y)", "\n\n"};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        write_var_count(5'd3);
        text.delete();
        send_text(1'b0, 1'b0);
        foreach (cases[k]) begin
            text.delete();
            for (int j = 0; j < cases[k].len(); j++) text.push_back(cases[k][j]);
            send_text(1'b0, 1'b0);
        end
        push_item(8'h00, 1'b0, 1'b0);
        push_item(8'h5A, 1'b0, 1'b1);
        push_item(8'hFF, 1'b0, 1'b0);
        push_item(8'hA5, 1'b1, 1'b1);
        settle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            limit = p == 0 ? 5'd26 : p == 1 ? 5'd0 : 5'($urandom_range(1, 25));
            write_var_count(limit);
            calm = $urandom_range(0, 3) == 0;
            if (p == 0) begin
                add_deep(DEPTH_LIMIT + 1, $urandom_range(DEPTH_LIMIT - 2, DEPTH_LIMIT + 4));
                add_deep(DEPTH_LIMIT, DEPTH_LIMIT);
            end
            goal = fed_items + PHASE_ITEMS;
            while (fed_items < goal) add_expression();
            settle();
        end

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: expression_syntax_checker.f
rtl/esc_pkg.sv
rtl/esc_char_class.sv
rtl/esc_scan.sv
rtl/expression_syntax_checker.sv
test/tb.sv
